@@ sv/zbbd_pkg.sv @@
// Shared constants, result codes and payload layout for the banked bus decoder.
`timescale 1ns / 1ps

package zbbd_pkg;

  // Internal RAM depth (power of two, 1024 to 8192 words); the RAM mirrors over 0x0000-0x1FFF
  localparam int unsigned RAM_DEPTH = 8192;
  localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);

  // Bank register width, 1 to 9 bits
  localparam int unsigned BANK_BITS = 9;
  localparam int unsigned BANK_CW   = $clog2(BANK_BITS + 1);

  // Bus and target widths
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned TADDR_W = 24;
  localparam int unsigned WIN_OFS_W = 15;
  localparam int unsigned TGT_W   = 3;

  // Result tdata width: target_addr, target_write, target_data, read_value, bank_changed
  localparam int unsigned OUT_FIELDS_W = TADDR_W + 1 + DATA_W + DATA_W + 1;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  // Input tdata width: bus_addr, write_value
  localparam int unsigned IN_TDATA_W   = ((ADDR_W + DATA_W + 7) / 8) * 8;

  // Region codes: top three address bits
  localparam logic [2:0] REG_RAM  = 3'd0;
  localparam logic [2:0] REG_FM   = 3'd2;
  localparam logic [2:0] REG_CTRL = 3'd3;

  // Fixed addresses
  localparam logic [ADDR_W-1:0] FM_BASE   = 16'h4000;
  localparam logic [ADDR_W-1:0] BANK_ADDR = 16'h6000;
  localparam logic [ADDR_W-1:0] PSG_ADDR  = 16'h7F11;

  // Access kinds
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Target codes
  typedef enum logic [TGT_W-1:0] {
    T_RAM  = 3'd0,
    T_NONE = 3'd1,
    T_FM   = 3'd2,
    T_PSG  = 3'd3,
    T_WIN  = 3'd4
  } target_t;

  // Decoded result of one access, ahead of the RAM read data
  typedef struct packed {
    target_t             target;
    logic [TADDR_W-1:0]  target_addr;
    logic                target_write;
    logic [DATA_W-1:0]   target_data;
    logic                ram_read;
    logic                bank_changed;
  } dec_t;

endpackage

@@ sv/zbbd_ram.sv @@
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module zbbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One access per cycle; read data holds while not enabled
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/z80_banked_bus_decoder.sv @@
// Top level: sound CPU bus decoder with internal RAM, FM/PSG routing and banked window.
`timescale 1ns / 1ps

// One CPU bus word in, one decode word out, one word per clock sustained while
// out_tready stays high. A word is decoded in the cycle it is accepted (the RAM port
// and the bank shift register act on that edge), is held in a decode stage for the
// registered RAM read data, then sits in the output register. The single RAM port
// serves one access per word. Reads of internal RAM words that were never written
// return undefined data. No clearing pass after reset.
module z80_banked_bus_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [15:0] bus_addr, [23:16] write_value
  input  logic [zbbd_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] func
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [23:0] target_addr, [24] target_write, [32:25] target_data,
  // [40:33] read_value, [41] bank_changed, [47:42] zero
  output logic [zbbd_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [2:0] target
  output logic [zbbd_pkg::TGT_W-1:0]       out_tuser
);

  import zbbd_pkg::*;

  // Input fields
  logic                 in_wr;
  logic [ADDR_W-1:0]    in_addr;
  logic [DATA_W-1:0]    in_wval;
  logic                 in_acc;

  // Bank shift register
  logic [BANK_BITS-1:0] bank_r, bank_nxt;
  logic [BANK_BITS-1:0] accum_r, accum_nxt;
  logic [BANK_CW-1:0]   cnt_r, cnt_nxt;
  logic                 bank_wr;
  logic                 bank_chg;

  // Decode stage and output register
  dec_t                 dec;
  dec_t                 s1_r, s1_nxt;
  logic                 s1_vld_r, s1_vld_nxt;
  logic                 s1_adv;
  logic                 out_vld_r, out_vld_nxt;
  target_t              out_tgt_r, out_tgt_nxt;
  logic [OUT_FIELDS_W-1:0] out_f_r, out_f_nxt;

  // RAM port
  logic                 ram_en;
  logic                 ram_we;
  logic [DATA_W-1:0]    ram_rdata;
  logic [DATA_W-1:0]    rd_val;

  assign in_wr   = in_tuser;
  assign in_addr = in_tdata[ADDR_W-1:0];
  assign in_wval = in_tdata[ADDR_W +: DATA_W];

  // Handshake: decode stage moves on when the output register is free or drained
  assign s1_adv    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // Address decode
  always_comb begin
    dec              = '0;
    dec.target       = T_NONE;
    bank_wr          = 1'b0;
    case (in_addr[ADDR_W-1 -: 3])
      REG_RAM: begin
        dec.target      = T_RAM;
        dec.target_addr = TADDR_W'(in_addr[RAM_AW-1:0]);
        dec.target_write = (in_wr == FUNC_WRITE);
        dec.ram_read    = (in_wr == FUNC_READ);
      end
      REG_FM: begin
        if (in_addr[12:2] == '0) begin
          dec.target      = T_FM;
          dec.target_addr = TADDR_W'(in_addr[1:0]);
          dec.target_write = (in_wr == FUNC_WRITE);
        end
      end
      REG_CTRL: begin
        if (in_wr == FUNC_WRITE && in_addr == PSG_ADDR) begin
          dec.target       = T_PSG;
          dec.target_write = 1'b1;
        end else if (in_wr == FUNC_WRITE && in_addr == BANK_ADDR) begin
          bank_wr = 1'b1;
        end
      end
      default: begin
        // Window: bank * 0x8000 + low 15 bits, 24-bit result
        if (in_addr[ADDR_W-1]) begin
          dec.target      = T_WIN;
          dec.target_addr = (TADDR_W'(bank_r) << WIN_OFS_W) |
                            TADDR_W'(in_addr[WIN_OFS_W-1:0]);
        end
      end
    endcase
    if (dec.target_write) begin
      dec.target_data = in_wval;
    end
  end

  // Bank bits shift in LSB first; latch on the last one
  always_comb begin
    bank_nxt     = bank_r;
    accum_nxt    = accum_r;
    cnt_nxt      = cnt_r;
    bank_chg     = 1'b0;
    if (in_acc && bank_wr) begin
      accum_nxt = accum_r | (BANK_BITS'(in_wval[0]) << cnt_r);
      cnt_nxt   = cnt_r + 1'b1;
      if (cnt_nxt >= BANK_CW'(BANK_BITS)) begin
        bank_nxt  = accum_nxt;
        accum_nxt = '0;
        cnt_nxt   = '0;
        bank_chg  = 1'b1;
      end
    end
  end

  // RAM access at accept time
  assign ram_en = in_acc && (in_addr[ADDR_W-1 -: 3] == REG_RAM);
  assign ram_we = (in_wr == FUNC_WRITE);

  zbbd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (in_addr[RAM_AW-1:0]),
    .wdata (in_wval),
    .rdata (ram_rdata)
  );

  // Stage and output register next values
  always_comb begin
    s1_nxt      = s1_r;
    s1_vld_nxt  = s1_vld_r;
    out_vld_nxt = out_vld_r;
    out_tgt_nxt = out_tgt_r;
    out_f_nxt   = out_f_r;
    rd_val      = s1_r.ram_read ? ram_rdata : '0;
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (s1_adv) begin
      out_vld_nxt = 1'b1;
      out_tgt_nxt = s1_r.target;
      out_f_nxt   = {s1_r.bank_changed, rd_val, s1_r.target_data,
                     s1_r.target_write, s1_r.target_addr};
      s1_vld_nxt  = 1'b0;
    end
    if (in_acc) begin
      s1_nxt              = dec;
      s1_nxt.bank_changed = bank_chg;
      s1_vld_nxt          = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r    <= '0;
      accum_r   <= '0;
      cnt_r     <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      bank_r    <= bank_nxt;
      accum_r   <= accum_nxt;
      cnt_r     <= cnt_nxt;
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    s1_r      <= s1_nxt;
    out_tgt_r <= out_tgt_nxt;
    out_f_r   <= out_f_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_tgt_r;
  assign out_tdata  = OUT_TDATA_W'(out_f_r);

`ifndef SYNTHESIS
  // Bit counter never reaches the bank width: the latch clears it
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < BANK_CW'(BANK_BITS))
    else $error("bank bit count out of range");

  // Read data only ever comes back from the internal RAM
  a_rd_ram_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_tgt_r != T_RAM |-> out_f_r[TADDR_W+1+DATA_W +: DATA_W] == '0)
    else $error("read data on non-RAM target");

  // A bank latch carries no target and no strobe
  a_bank_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_f_r[OUT_FIELDS_W-1] |-> out_tgt_r == T_NONE && !out_f_r[TADDR_W])
    else $error("bank change with target or strobe");

  // Bank register moves only on a latch accepted in the previous cycle
  a_bank_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && bank_wr) |=> $stable(bank_r))
    else $error("bank register changed without a bank write");
`endif

endmodule
